/* design/pgs_pkg.sv */
// Types and constants shared by the stub encoder pipeline.
package pgs_pkg;

    typedef enum logic [1:0] {
        ARCH_X86  = 2'd0,
        ARCH_A64  = 2'd1,
        ARCH_RV   = 2'd2,
        ARCH_NONE = 2'd3
    } t_arch;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ARCH  = 2'd1,
        ST_ALIGN = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // x86-64 stub
    localparam logic [31:0] X86_ENDBR  = 32'hfa1e0ff3;
    localparam logic [31:0] X86_JMP    = 32'h000025ff;
    localparam logic [31:0] X86_PAD_HI = 32'hcccc0000;
    localparam logic [31:0] X86_PAD    = 32'hcccccccc;
    localparam logic [65:0] X86_NEXT   = 66'd10;

    // AArch64 stub
    localparam logic [31:0] A64_ADRP = 32'h90000010;
    localparam logic [31:0] A64_LDR  = 32'hf9400211;
    localparam logic [31:0] A64_BR   = 32'hd61f0220;
    localparam logic [31:0] A64_NOP  = 32'hd503201f;

    // RISC-V64 stub
    localparam logic [31:0] RV_AUIPC = 32'h00000e17;
    localparam logic [31:0] RV_LD    = 32'h000e3e03;
    localparam logic [31:0] RV_JALR  = 32'h000e0367;
    localparam logic [31:0] RV_NOP   = 32'h00000013;

    // After stage 1: raw deltas and flags
    typedef struct packed {
        t_arch       arch;
        logic [64:0] delta;      // slot - stub, signed
        logic [52:0] pg_diff;    // page(slot) - page(stub), signed
        logic        wrap;       // stub + 10 overflows
        logic        misalign;
        logic [8:0]  off;        // slot[11:3]
    } t_s1;

    // After stage 2: status and instruction fields
    typedef struct packed {
        t_arch       arch;
        t_status     status;
        logic [31:0] disp;
        logic [20:0] pages;
        logic [8:0]  off;
        logic [19:0] hi;
        logic [11:0] lo;
    } t_s2;

endpackage

/* design/pgs_if.sv */
// Request and result channel interfaces of the stub encoder.
interface pgs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  arch;
    logic [63:0] stub_address;
    logic [63:0] slot_address;

    modport source (output valid, output arch, output stub_address, output slot_address,
                    input ready);
    modport sink   (input valid, input arch, input stub_address, input slot_address,
                    output ready);
endinterface

interface pgs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;

    modport source (output valid, output status, output word0, output word1,
                    output word2, output word3, input ready);
    modport sink   (input valid, input status, input word0, input word1,
                    input word2, input word3, output ready);
endinterface

/* design/pltgot_stub_encoder_unit.sv */
// Top level of the PLT/GOT jump stub encoder.
// Three register stages lie between request accept and result valid.
// Throughput: one request per cycle; each stage holds its item while the next is full,
// so a stalled output backs the pipeline up without loss.
// Reset: synchronous, active low; clears the stage valid bits only.
module pltgot_stub_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgs_req_if.sink     i_req,
    pgs_rsp_if.source   o_rsp
);
    import pgs_pkg::*;

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;

    pgs_delta u_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_arch  (i_req.arch),
        .i_stub  (i_req.stub_address),
        .i_slot  (i_req.slot_address),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    pgs_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    pgs_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_rsp   (o_rsp)
    );

endmodule

/* design/pgs_delta.sv */
// Stage 1: address differences, wrap and alignment flags.
module pgs_delta (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_arch,
    input  logic [63:0]   i_stub,
    input  logic [63:0]   i_slot,
    output logic          o_valid,
    input  logic          i_ready,
    output pgs_pkg::t_s1  o_data
);
    import pgs_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;
    logic en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.arch     = t_arch'(i_arch);
        n_data.delta    = {1'b0, i_slot} - {1'b0, i_stub};
        n_data.pg_diff  = {1'b0, i_slot[63:12]} - {1'b0, i_stub[63:12]};
        n_data.wrap     = (&i_stub[63:4]) && (i_stub[3:0] >= 4'd6);
        n_data.misalign = (|i_stub[1:0]) || (|i_slot[2:0]);
        n_data.off      = i_slot[11:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* design/pgs_check.sv */
// Stage 2: range checks, status and immediate fields.
module pgs_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pgs_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pgs_pkg::t_s2  o_data
);
    import pgs_pkg::*;

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic        en;
    logic [65:0] dx;
    logic        x_ok;
    logic        a_ok;
    logic        r_ok;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // disp relative to stub + 10
    assign dx   = {i_data.delta[64], i_data.delta} - X86_NEXT;
    assign x_ok = !i_data.wrap && ((&dx[65:31]) || !(|dx[65:31]));
    assign a_ok = (&i_data.pg_diff[52:20]) || !(|i_data.pg_diff[52:20]);
    // upper bound 0x7ffff7ff keeps the rounded hi20 from overflowing
    assign r_ok = ((&i_data.delta[64:31]) || !(|i_data.delta[64:31]))
                  && !(!i_data.delta[64] && (&i_data.delta[30:11]));

    always_comb begin
        n_data.arch  = i_data.arch;
        n_data.disp  = dx[31:0];
        n_data.pages = i_data.pg_diff[20:0];
        n_data.off   = i_data.off;
        n_data.hi    = i_data.delta[31:12] + {19'd0, i_data.delta[11]};
        n_data.lo    = i_data.delta[11:0];
        unique case (i_data.arch)
            ARCH_X86: n_data.status = x_ok ? ST_OK : ST_RANGE;
            ARCH_A64: n_data.status = i_data.misalign ? ST_ALIGN :
                                      (a_ok ? ST_OK : ST_RANGE);
            ARCH_RV:  n_data.status = i_data.misalign ? ST_ALIGN :
                                      (r_ok ? ST_OK : ST_RANGE);
            default:  n_data.status = ST_ARCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* design/pgs_pack.sv */
// Stage 3: instruction word assembly into the output register.
module pgs_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pgs_pkg::t_s2    i_data,
    pgs_rsp_if.source       o_rsp
);
    import pgs_pkg::*;

    logic        r_valid;
    logic [1:0]  r_status;
    logic [31:0] r_word0;
    logic [31:0] r_word1;
    logic [31:0] r_word2;
    logic [31:0] r_word3;
    logic [31:0] n_word0;
    logic [31:0] n_word1;
    logic [31:0] n_word2;
    logic [31:0] n_word3;
    logic        en;

    assign en      = !r_valid || o_rsp.ready;
    assign o_ready = en;

    assign o_rsp.valid  = r_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.word0  = r_word0;
    assign o_rsp.word1  = r_word1;
    assign o_rsp.word2  = r_word2;
    assign o_rsp.word3  = r_word3;

    always_comb begin
        n_word0 = '0;
        n_word1 = '0;
        n_word2 = '0;
        n_word3 = '0;
        if (i_data.status == ST_OK) begin
            unique case (i_data.arch)
                ARCH_X86: begin
                    n_word0 = X86_ENDBR;
                    n_word1 = X86_JMP | {i_data.disp[15:0], 16'd0};
                    n_word2 = X86_PAD_HI | {16'd0, i_data.disp[31:16]};
                    n_word3 = X86_PAD;
                end
                ARCH_A64: begin
                    // adrp immlo in 30:29, immhi in 23:5
                    n_word0 = A64_ADRP | {1'b0, i_data.pages[1:0], 5'd0,
                                          i_data.pages[20:2], 5'd0};
                    n_word1 = A64_LDR | {13'd0, i_data.off, 10'd0};
                    n_word2 = A64_BR;
                    n_word3 = A64_NOP;
                end
                ARCH_RV: begin
                    n_word0 = RV_AUIPC | {i_data.hi, 12'd0};
                    n_word1 = RV_LD | {i_data.lo, 20'd0};
                    n_word2 = RV_JALR;
                    n_word3 = RV_NOP;
                end
                default: begin
                    n_word0 = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_status <= i_data.status;
            r_word0  <= n_word0;
            r_word1  <= n_word1;
            r_word2  <= n_word2;
            r_word3  <= n_word3;
        end
    end

endmodule

/* test/pltgot_stub_encoder_unit_tb.sv */
// Self-checking testbench for the PLT/GOT jump stub encoder.
`timescale 1ns / 1ps

module pltgot_stub_encoder_unit_tb;
    import pgs_pkg::*;

    typedef struct {
        t_arch       arch;
        logic [63:0] stub_addr;
        logic [63:0] slot_addr;
    } t_stub_request;

    typedef struct {
        t_status     status;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
    } t_stub_words;

    localparam logic signed [64:0] DISP32_MAX   = 65'sd2147483647;
    localparam logic signed [64:0] DISP32_MIN   = -65'sd2147483648;
    localparam logic signed [64:0] RV_DELTA_MAX = 65'sd2147481599; // 0x7ffff7ff
    localparam logic signed [52:0] PAGES_MAX    = 53'sd1048575;
    localparam logic signed [52:0] PAGES_MIN    = -53'sd1048576;
    localparam logic [63:0]        X86_LAST_STUB = 64'hffff_ffff_ffff_fff5;
    localparam int RANDOM_PER_PHASE = 238;

    logic i_clk;
    logic i_rst_n;

    pgs_req_if req_if ();
    pgs_rsp_if rsp_if ();

    pltgot_stub_encoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_stub_request request_q[$];
    t_stub_words   expected_stub_q[$];
    t_stub_request next_req;
    t_stub_words   oldest_stub;
    logic          req_taken;
    int            send_idle_pct;
    int            stall_pct;
    int            failure_count;

    // Encoded stub for one request
    function automatic t_stub_words encode_stub(t_arch arch, logic [63:0] stub,
                                                logic [63:0] slot);
        t_stub_words        r;
        logic signed [64:0] delta;
        logic signed [52:0] pages;
        logic [63:0]        rounded;
        r.status = ST_OK;
        r.word0  = '0;
        r.word1  = '0;
        r.word2  = '0;
        r.word3  = '0;
        case (arch)
            ARCH_X86: begin
                delta = $signed({1'b0, slot}) - $signed({1'b0, stub + 64'd10});
                if (stub > X86_LAST_STUB || delta > DISP32_MAX || delta < DISP32_MIN) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word0 = X86_ENDBR;
                    r.word1 = X86_JMP | {delta[15:0], 16'h0000};
                    r.word2 = X86_PAD_HI | {16'h0000, delta[31:16]};
                    r.word3 = X86_PAD;
                end
            end
            ARCH_A64: begin
                pages = $signed({1'b0, slot[63:12]}) - $signed({1'b0, stub[63:12]});
                if (stub[1:0] != 2'b00 || slot[2:0] != 3'b000) begin
                    r.status = ST_ALIGN;
                end else if (pages > PAGES_MAX || pages < PAGES_MIN) begin
                    r.status = ST_RANGE;
                end else begin
                    // immlo at 30:29, immhi at 23:5
                    r.word0 = A64_ADRP | {1'b0, pages[1:0], 5'b00000, pages[20:2], 5'b00000};
                    r.word1 = A64_LDR | {13'h0000, slot[11:3], 10'h000};
                    r.word2 = A64_BR;
                    r.word3 = A64_NOP;
                end
            end
            ARCH_RV: begin
                delta = $signed({1'b0, slot}) - $signed({1'b0, stub});
                if (stub[1:0] != 2'b00 || slot[2:0] != 3'b000) begin
                    r.status = ST_ALIGN;
                end else if (delta > RV_DELTA_MAX || delta < DISP32_MIN) begin
                    r.status = ST_RANGE;
                end else begin
                    rounded = delta[63:0] + 64'h800;
                    r.word0 = RV_AUIPC | {rounded[31:12], 12'h000};
                    r.word1 = RV_LD | {delta[11:0], 20'h00000};
                    r.word2 = RV_JALR;
                    r.word3 = RV_NOP;
                end
            end
            default: begin
                r.status = ST_ARCH;
            end
        endcase
        return r;
    endfunction

    // Deltas of mixed size, some near the range limits, some fully random or misaligned
    function automatic t_stub_request random_request();
        t_stub_request r;
        logic [31:0]   rnd;
        logic [63:0]   delta;
        logic [63:0]   edge_base;
        logic [63:0]   nudge;
        int unsigned   pick;
        rnd  = $urandom;
        pick = $urandom_range(99);
        if (pick < 8) begin
            r.arch = ARCH_NONE;
        end else begin
            r.arch = t_arch'($urandom_range(2));
        end
        r.stub_addr = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick == 0) begin
            r.stub_addr = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(40));
        end else if (pick == 1) begin
            r.stub_addr = 64'($urandom_range(8191));
        end
        case ($urandom_range(4))
            0: delta = {{52{rnd[31]}}, rnd[11:0]};
            1: delta = {{32{rnd[31]}}, rnd};
            2: delta = {{29{rnd[31]}}, rnd, 3'b000};
            3: begin
                case (r.arch)
                    ARCH_X86: edge_base = rnd[0] ? 64'h8000_0009 : 64'hffff_ffff_8000_000a;
                    ARCH_A64: edge_base = rnd[0] ? 64'h1_0000_0000 : 64'hffff_ffff_0000_0000;
                    default:  edge_base = rnd[0] ? 64'h7fff_f7ff : 64'hffff_ffff_8000_0000;
                endcase
                if (r.arch == ARCH_A64) begin
                    nudge = {{52{rnd[31]}}, rnd[12:1]};
                end else begin
                    nudge = {{59{rnd[31]}}, rnd[5:1]};
                end
                delta = edge_base + nudge;
            end
            default: delta = {$urandom, $urandom};
        endcase
        r.slot_addr = r.stub_addr + delta;
        if ((r.arch == ARCH_A64 || r.arch == ARCH_RV) && $urandom_range(9) != 0) begin
            r.stub_addr[1:0] = 2'b00;
            r.slot_addr[2:0] = 3'b000;
        end
        return r;
    endfunction

    task automatic add_request(t_arch arch, logic [63:0] stub, logic [63:0] slot);
        t_stub_request r;
        r.arch      = arch;
        r.stub_addr = stub;
        r.slot_addr = slot;
        request_q.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = request_q.pop_front();
                req_if.valid        <= 1'b1;
                req_if.arch         <= next_req.arch;
                req_if.stub_address <= next_req.stub_addr;
                req_if.slot_address <= next_req.slot_addr;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor and scoreboard
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_stub_q.size() == 0) begin
                    failure_count++;
                    if (failure_count <= 10)
                        $display("result with nothing expected: status %0d words %h %h %h %h",
                                 rsp_if.status, rsp_if.word0, rsp_if.word1,
                                 rsp_if.word2, rsp_if.word3);
                end else begin
                    oldest_stub = expected_stub_q.pop_front();
                    if (rsp_if.status !== oldest_stub.status ||
                        rsp_if.word0 !== oldest_stub.word0 ||
                        rsp_if.word1 !== oldest_stub.word1 ||
                        rsp_if.word2 !== oldest_stub.word2 ||
                        rsp_if.word3 !== oldest_stub.word3) begin
                        failure_count++;
                        if (failure_count <= 10)
                            $display("mismatch: expected %0d %h %h %h %h, got %0d %h %h %h %h",
                                     oldest_stub.status, oldest_stub.word0,
                                     oldest_stub.word1, oldest_stub.word2,
                                     oldest_stub.word3, rsp_if.status, rsp_if.word0,
                                     rsp_if.word1, rsp_if.word2, rsp_if.word3);
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                expected_stub_q.push_back(encode_stub(t_arch'(req_if.arch),
                                                      req_if.stub_address,
                                                      req_if.slot_address));
        end
    end

    initial begin
        #2_000_000;
        $display("pltgot_stub_encoder_unit_tb: errors");
        $finish;
    end

    initial begin
        int send_idle_by_phase[4];
        int stall_by_phase[4];
        send_idle_by_phase = '{0, 54, 0, 33};
        stall_by_phase     = '{0, 0, 54, 33};
        failure_count       = 0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.arch         = ARCH_X86;
        req_if.stub_address = '0;
        req_if.slot_address = '0;
        rsp_if.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // x86-64: zero displacement, both displacement limits, stub+10 wrap edge
        add_request(ARCH_X86, 64'h0, 64'd10);
        add_request(ARCH_X86, 64'h1000, 64'h1000 + 64'd10 + 64'h7fff_ffff);
        add_request(ARCH_X86, 64'h1000, 64'h1000 + 64'd10 + 64'h8000_0000);
        add_request(ARCH_X86, 64'h9000_0000, 64'h9000_0000 + 64'd10 - 64'h8000_0000);
        add_request(ARCH_X86, 64'h9000_0000, 64'h9000_0000 + 64'd9 - 64'h8000_0000);
        add_request(ARCH_X86, X86_LAST_STUB, 64'hffff_ffff_ffff_ffff);
        add_request(ARCH_X86, X86_LAST_STUB + 64'd1, 64'hffff_ffff_ffff_ffff);
        add_request(ARCH_X86, 64'hffff_ffff_ffff_ffff, 64'h0);
        // AArch64: near slot, misalignment of each address, page delta limits
        add_request(ARCH_A64, 64'h1000, 64'h1008);
        add_request(ARCH_A64, 64'h1002, 64'h1008);
        add_request(ARCH_A64, 64'h1000, 64'h1004);
        add_request(ARCH_A64, 64'h0, 64'h0000_0000_ffff_fff8);
        add_request(ARCH_A64, 64'h0, 64'h0000_0001_0000_0000);
        add_request(ARCH_A64, 64'h0000_0001_0000_0ffc, 64'h0);
        add_request(ARCH_A64, 64'h0000_0001_0000_1000, 64'h0);
        add_request(ARCH_A64, 64'hffff_ffff_ffff_fffc, 64'hffff_ffff_ffff_fff8);
        // RISC-V64: zero delta, rounding carry into hi20, delta limits, misalignment
        add_request(ARCH_RV, 64'h1000, 64'h1000);
        add_request(ARCH_RV, 64'h1000, 64'h1800);
        add_request(ARCH_RV, 64'h4, 64'h7fff_f800);
        add_request(ARCH_RV, 64'h4, 64'h7fff_f808);
        add_request(ARCH_RV, 64'h8000_0000, 64'h0);
        add_request(ARCH_RV, 64'h8000_0008, 64'h0);
        add_request(ARCH_RV, 64'h1001, 64'h2000);
        // Unsupported target
        add_request(ARCH_NONE, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        add_request(ARCH_NONE, 64'h0, 64'h0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                request_q.push_back(random_request());
            // Drain fully before the next phase; the sender sits idle meanwhile
            do begin
                @(posedge i_clk);
                #1;
            end while (request_q.size() != 0 || (req_if.valid && !req_taken) ||
                       expected_stub_q.size() != 0);
        end

        repeat (10) @(posedge i_clk);
        failure_count += expected_stub_q.size();
        if (failure_count == 0) begin
            $display("pltgot_stub_encoder_unit_tb: clean");
        end else begin
            $display("pltgot_stub_encoder_unit_tb: errors");
        end
        $finish;
    end

endmodule
